### src/lsb_stego_pixel_embed_top_defines.svh
// Assertion macros used by the embedder's top level
`ifndef LSB_STEGO_PIXEL_EMBED_TOP_DEFINES_SVH
`define LSB_STEGO_PIXEL_EMBED_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define LSPE_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk, off while rst is high
`define LSPE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: lbl");

`endif

### src/lspe_pkg.sv
// Types and constants of the LSB pixel embedder
`timescale 1ns / 1ps
`default_nettype none
package lspe_pkg;

  // Embedding modes
  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBE = 2'd2;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Register indexes
  localparam logic REG_EMBED_MODE     = 1'b0;
  localparam logic REG_MESSAGE_LENGTH = 1'b1;

  localparam int MaxUsed   = 12;  // most bits one pixel takes
  localparam int CountW    = 4;   // width of a bit count
  localparam int ChunkBits = 8;   // bits in one message chunk
  localparam int NibBits   = 4;   // bits per channel in LSB4
  localparam int LenW      = 24;  // message length width
  localparam logic [6:0] HIGH_VAL_TOP = 7'h7F;  // value 254 or 255

  // Command to the bit buffer
  typedef struct packed {
    logic              load;   // append count leading bits of chunk
    logic              shift;  // drop count bits from the front
    logic [7:0]        chunk;
    logic [CountW-1:0] count;
  } buf_cmd_t;

endpackage
`default_nettype wire

### src/lspe_if.sv
// Valid/ready channel interfaces of the LSB pixel embedder
`timescale 1ns / 1ps
`default_nettype none
interface lspe_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] message_chunk;
  logic [3:0] chunk_bits;

  modport source(output valid, command, red_in, green_in, blue_in, message_chunk,
                 chunk_bits, input ready);
  modport sink(input valid, command, red_in, green_in, blue_in, message_chunk,
               chunk_bits, output ready);
endinterface

interface lspe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [3:0] bits_hidden;
  logic       message_done;
  logic       underrun;

  modport source(output valid, red_out, green_out, blue_out, bits_hidden,
                 message_done, underrun, input ready);
  modport sink(input valid, red_out, green_out, blue_out, bits_hidden,
               message_done, underrun, output ready);
endinterface
`default_nettype wire

### src/lsb_stego_pixel_embed_top.sv
// Top level of the LSB pixel embedder
//
//   channel    | dir | carries
//   -----------+-----+------------------------------------------------------
//   pixel_in   | in  | command, cover pixel, message chunk and chunk length
//   pixel_out  | out | rewritten pixel, bits hidden, done and underrun flags
//   cfg_*      | in  | register writes: embed mode, message length
//
// One transaction per cycle in both directions unless the output stalls; a pixel passes
// from the input register into the result register, waiting while that one is full.
// The fill count and the front-bit shift line are updated together.
// Load transactions produce no result and never wait on the output side.
// rst clears control state and the configuration registers; the bit buffer needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_stego_pixel_embed_top_defines.svh"
module lsb_stego_pixel_embed_top #(
  parameter int BUFFER_BITS = 64
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire                        cfg_index,
  input  wire  [lspe_pkg::LenW-1:0]  cfg_wdata,
  lspe_in_if.sink                    pixel_in,
  lspe_out_if.source                 pixel_out
);
  import lspe_pkg::*;

  localparam int FW = $clog2(BUFFER_BITS + 1);

  logic [1:0]        embed_mode;
  logic [LenW-1:0]   message_length;
  logic [LenW-1:0]   bits_embedded;
  logic [LenW-1:0]   bits_embedded_next;

  logic              in_valid;
  logic              in_cmd;
  logic [7:0]        in_red;
  logic [7:0]        in_green;
  logic [7:0]        in_blue;
  logic [7:0]        in_chunk;
  logic [3:0]        in_nbits;

  logic              out_valid;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [CountW-1:0] out_used;
  logic              out_done;
  logic              out_underrun;

  logic              advance;
  logic              pix_fire;
  buf_cmd_t          bcmd;
  logic [MaxUsed-1:0] front;
  logic [FW-1:0]     fill;
  logic [7:0]        red_new;
  logic [7:0]        green_new;
  logic [7:0]        blue_new;
  logic [CountW-1:0] used;
  logic              underrun;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      embed_mode     <= MODE_LSB1;
      message_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EMBED_MODE:     embed_mode     <= cfg_wdata[1:0];
        REG_MESSAGE_LENGTH: message_length <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Stage handshake: loads always move on, pixels need room at the output
  assign advance        = in_valid && (in_cmd == CMD_LOAD || !out_valid || pixel_out.ready);
  assign pix_fire       = advance && in_cmd == CMD_PIXEL;
  assign pixel_in.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel_in.ready) begin
      in_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_in.valid && pixel_in.ready) begin
      in_cmd   <= pixel_in.command;
      in_red   <= pixel_in.red_in;
      in_green <= pixel_in.green_in;
      in_blue  <= pixel_in.blue_in;
      in_chunk <= pixel_in.message_chunk;
      in_nbits <= pixel_in.chunk_bits;
    end
  end

  // Buffer command
  always_comb begin
    bcmd.load  = advance && in_cmd == CMD_LOAD;
    bcmd.shift = pix_fire && !underrun;
    bcmd.chunk = in_chunk;
    bcmd.count = (in_cmd == CMD_LOAD) ? in_nbits : used;
  end

  lspe_bit_buffer #(
    .BUFFER_BITS(BUFFER_BITS),
    .FW         (FW)
  ) u_buffer (
    .clk  (clk),
    .rst  (rst),
    .cmd  (bcmd),
    .front(front),
    .fill (fill)
  );

  lspe_embed #(
    .FW(FW)
  ) u_embed (
    .embed_mode    (embed_mode),
    .message_length(message_length),
    .bits_embedded (bits_embedded),
    .fill          (fill),
    .front         (front),
    .red           (in_red),
    .green         (in_green),
    .blue          (in_blue),
    .red_new       (red_new),
    .green_new     (green_new),
    .blue_new      (blue_new),
    .used          (used),
    .underrun      (underrun)
  );

  // Hidden-bit count
  assign bits_embedded_next = bits_embedded + LenW'(used);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_embedded <= '0;
    end else if (pix_fire) begin
      bits_embedded <= bits_embedded_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_fire) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      out_red      <= red_new;
      out_green    <= green_new;
      out_blue     <= blue_new;
      out_used     <= used;
      out_done     <= bits_embedded_next >= message_length;
      out_underrun <= underrun;
    end
  end

  assign pixel_out.valid        = out_valid;
  assign pixel_out.red_out      = out_red;
  assign pixel_out.green_out    = out_green;
  assign pixel_out.blue_out     = out_blue;
  assign pixel_out.bits_hidden  = out_used;
  assign pixel_out.message_done = out_done;
  assign pixel_out.underrun     = out_underrun;

  // Checks
  `LSPE_ASSERT_IMPLY(a_underrun_no_bits, out_valid && out_underrun, out_used == '0)
  `LSPE_ASSERT_IMPLY(a_used_bounded, out_valid, out_used <= CountW'(MaxUsed))
  `LSPE_ASSERT_IMPLY(a_fill_bounded, 1'b1, fill <= FW'(BUFFER_BITS))
  `LSPE_ASSERT_NEXT(a_fill_drops, bcmd.shift, fill == $past(fill) - FW'($past(used)))

endmodule
`default_nettype wire

### src/lspe_bit_buffer.sv
// First-in first-out bit buffer built as a shift line with a fill count
`timescale 1ns / 1ps
`default_nettype none
module lspe_bit_buffer #(
  parameter int BUFFER_BITS = 64,
  parameter int FW          = $clog2(BUFFER_BITS + 1)
) (
  input  wire                    clk,
  input  wire                    rst,
  input  lspe_pkg::buf_cmd_t     cmd,
  output logic [lspe_pkg::MaxUsed-1:0] front,
  output logic [FW-1:0]          fill
);
  import lspe_pkg::*;

  logic [BUFFER_BITS-1:0] bits;
  logic [BUFFER_BITS-1:0] bits_next;
  logic [BUFFER_BITS-1:0] shifted;
  logic [FW-1:0]          fill_next;
  logic [CountW-1:0]      load_n;
  logic [FW:0]            load_sum;

  // Shift candidates: entry j takes entry j+u when u bits leave
  for (genvar j = 0; j < BUFFER_BITS; j++) begin : g_entry
    logic [MaxUsed:0] cand;
    for (genvar u = 0; u <= MaxUsed; u++) begin : g_cand
      if (j + u < BUFFER_BITS) begin : g_in
        assign cand[u] = bits[j+u];
      end else begin : g_out
        assign cand[u] = bits[j];
      end
    end
    assign shifted[j] = cand[cmd.count];
  end

  // Front taps, oldest bit at index 0
  assign front = bits[MaxUsed-1:0];

  // Clamp a load to one chunk
  assign load_n   = (cmd.count > CountW'(ChunkBits)) ? CountW'(ChunkBits) : cmd.count;
  assign load_sum = {1'b0, fill} + (FW + 1)'(load_n);

  // Next contents: append at the fill position or shift out the front
  always_comb begin
    logic [FW-1:0] off;
    bits_next = bits;
    fill_next = fill;
    off       = '0;
    if (cmd.load) begin
      for (int j = 0; j < BUFFER_BITS; j++) begin
        off = FW'(j) - fill;
        if (FW'(j) >= fill && off < FW'(load_n)) begin
          bits_next[j] = cmd.chunk[~off[2:0]];
        end
      end
      fill_next = (load_sum > (FW + 1)'(BUFFER_BITS)) ? FW'(BUFFER_BITS) : load_sum[FW-1:0];
    end else if (cmd.shift) begin
      bits_next = shifted;
      fill_next = fill - FW'(cmd.count);
    end
  end

  // Contents need no reset; only the count does
  always_ff @(posedge clk) begin
    bits <= bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

### src/lspe_embed.sv
// Per-pixel embedding: bit budget, underrun check and channel rewrite
`timescale 1ns / 1ps
`default_nettype none
module lspe_embed #(
  parameter int FW = 7
) (
  input  wire  [1:0]                    embed_mode,
  input  wire  [lspe_pkg::LenW-1:0]     message_length,
  input  wire  [lspe_pkg::LenW-1:0]     bits_embedded,
  input  wire  [FW-1:0]                 fill,
  input  wire  [lspe_pkg::MaxUsed-1:0]  front,
  input  wire  [7:0]                    red,
  input  wire  [7:0]                    green,
  input  wire  [7:0]                    blue,
  output logic [7:0]                    red_new,
  output logic [7:0]                    green_new,
  output logic [7:0]                    blue_new,
  output logic [lspe_pkg::CountW-1:0]   used,
  output logic                          underrun
);
  import lspe_pkg::*;

  logic [LenW-1:0]   remaining;
  logic [CountW-1:0] cap;
  logic [CountW-1:0] need;
  logic [2:0]        high;
  logic [7:0]        ch [3];
  logic [7:0]        src [3];

  assign src[0] = red;
  assign src[1] = green;
  assign src[2] = blue;

  // Channels eligible in LSBE mode
  for (genvar c = 0; c < 3; c++) begin : g_high
    assign high[c] = (src[c][7:1] == HIGH_VAL_TOP);
  end

  // Bits left of the message
  assign remaining = (bits_embedded < message_length) ? message_length - bits_embedded : '0;

  // Capacity of this pixel
  always_comb begin
    unique case (embed_mode)
      MODE_LSB1: cap = CountW'(3);
      MODE_LSB4: cap = CountW'(MaxUsed);
      MODE_LSBE: cap = CountW'(high[0]) + CountW'(high[1]) + CountW'(high[2]);
      default:   cap = '0;
    endcase
  end

  assign need     = (remaining < LenW'(cap)) ? remaining[CountW-1:0] : cap;
  assign underrun = FW'(need) > fill;
  assign used     = underrun ? '0 : need;

  // Rewrite the channels
  always_comb begin
    logic [CountW-1:0] k;
    k = '0;
    for (int c = 0; c < 3; c++) begin
      ch[c] = src[c];
    end
    if (!underrun) begin
      unique case (embed_mode)
        MODE_LSB1: begin
          for (int c = 0; c < 3; c++) begin
            if (CountW'(c) < need) begin
              ch[c][0] = front[c];
            end
          end
        end
        MODE_LSB4: begin
          for (int c = 0; c < 3; c++) begin
            for (int b = 0; b < NibBits; b++) begin
              if (CountW'(NibBits * c + b) < need) begin
                ch[c][NibBits-1-b] = front[NibBits*c+b];
              end
            end
          end
        end
        MODE_LSBE: begin
          for (int c = 0; c < 3; c++) begin
            if (high[c]) begin
              if (k < need) begin
                ch[c][0] = front[k];
              end
              k = k + CountW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign red_new   = ch[0];
  assign green_new = ch[1];
  assign blue_new  = ch[2];

endmodule
`default_nettype wire
